// ===== rtl/core/mfd_pkg.sv =====
// ---------------------------------------------------------------------------
// mfd_pkg
// Shared types and constants of the masked frame deframer core.
// ---------------------------------------------------------------------------
package mfd_pkg;

  localparam int unsigned HDR_BYTES = 9;
  localparam int unsigned POS_W     = 4;
  localparam int unsigned LEN_W     = 32;
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned COUNT_W   = 33;

  // header position of the last header byte (the final key byte)
  localparam logic [POS_W-1:0] POS_KEY_END = POS_W'(HDR_BYTES - 1);
  localparam logic [POS_W-1:0] POS_PAYLOAD = POS_W'(HDR_BYTES);
  localparam logic [POS_W-1:0] POS_OPCODE  = POS_W'(0);
  localparam logic [POS_W-1:0] POS_LEN_END = POS_W'(4);

  typedef enum logic [1:0] {
    KIND_OPCODE  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_TRUNC   = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } in_word_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
    logic       error;
  } result_t;

endpackage

// ===== rtl/core/mfd_in_if.sv =====
// ---------------------------------------------------------------------------
// mfd_in_if
// Input channel: one received byte per word, with a last flag.
// ---------------------------------------------------------------------------
interface mfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== rtl/core/mfd_out_if.sv =====
// ---------------------------------------------------------------------------
// mfd_out_if
// Result channel: unmasked opcode or payload byte, or truncation report.
// ---------------------------------------------------------------------------
interface mfd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_error;

  modport source (output valid, output out_kind, output out_byte,
                  output out_last, output out_error, input ready);
  modport sink   (input valid, input out_kind, input out_byte,
                  input out_last, input out_error, output ready);
endinterface

// ===== rtl/core/mfd_in_stage.sv =====
// ---------------------------------------------------------------------------
// mfd_in_stage
// Input register: capture one word, hold it until the parser takes it.
// ---------------------------------------------------------------------------
module mfd_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  mfd_in_if.sink            in_ch,
  input  logic              take,
  output mfd_pkg::in_word_t word,
  output logic              word_valid
);

  logic              valid_r;
  logic              valid_nxt;
  mfd_pkg::in_word_t word_r;
  logic              accept;

  assign in_ch.ready = !valid_r || take;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload: load on accept only
  always_ff @(posedge clk) begin
    if (accept) begin
      word_r.data <= in_ch.in_byte;
      word_r.last <= in_ch.in_last;
    end
  end

  assign word       = word_r;
  assign word_valid = valid_r;

endmodule

// ===== rtl/core/mfd_parse.sv =====
// ---------------------------------------------------------------------------
// mfd_parse
// Frame state and unmasking logic: header capture, key select, size check.
// ---------------------------------------------------------------------------
module mfd_parse (
  input  logic              clk,
  input  logic              rst_n,
  input  mfd_pkg::in_word_t word,
  input  logic              word_valid,
  input  logic              out_free,
  output logic              take,
  output logic              res_load,
  output mfd_pkg::result_t  res
);

  logic [mfd_pkg::POS_W-1:0]   pos_r,  pos_nxt;
  logic [7:0]                  opc_r,  opc_nxt;
  logic [mfd_pkg::LEN_W-1:0]   len_r,  len_nxt;
  logic [mfd_pkg::KEY_W-1:0]   key_r,  key_nxt;
  logic [mfd_pkg::COUNT_W-1:0] cnt_r,  cnt_nxt;

  logic [mfd_pkg::KEY_W-1:0]   key_full;
  logic [mfd_pkg::COUNT_W-1:0] cnt_inc;
  logic [1:0]                  key_sel;
  logic [7:0]                  key_byte;
  logic                        has_res;

  assign key_full = {key_r[mfd_pkg::KEY_W-9:0], word.data};
  assign cnt_inc  = (cnt_r == {mfd_pkg::COUNT_W{1'b1}}) ? cnt_r
                                                          : cnt_r + 1'b1;
  assign key_sel  = cnt_r[1:0] + 2'd1;

  always_comb begin
    unique case (key_sel)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  // header bytes before the last key byte give nothing unless flagged last
  assign has_res  = word.last || (pos_r >= mfd_pkg::POS_KEY_END);
  assign take     = word_valid && (!has_res || out_free);
  assign res_load = take && has_res;

  always_comb begin
    pos_nxt = pos_r;
    opc_nxt = opc_r;
    len_nxt = len_r;
    key_nxt = key_r;
    cnt_nxt = cnt_r;
    res     = '{kind: mfd_pkg::KIND_TRUNC, data: 8'd0, last: 1'b1, error: 1'b1};
    priority if (pos_r < mfd_pkg::POS_KEY_END) begin
      priority if (pos_r == mfd_pkg::POS_OPCODE) begin
        opc_nxt = word.data;
      end else if (pos_r <= mfd_pkg::POS_LEN_END) begin
        len_nxt = {len_r[mfd_pkg::LEN_W-9:0], word.data};
      end else begin
        key_nxt = key_full;
      end
      pos_nxt = pos_r + 1'b1;
    end else if (pos_r == mfd_pkg::POS_KEY_END) begin
      key_nxt   = key_full;
      pos_nxt   = mfd_pkg::POS_PAYLOAD;
      res.kind  = mfd_pkg::KIND_OPCODE;
      res.data  = opc_r ^ key_full[mfd_pkg::KEY_W-1 -: 8];
      res.last  = word.last;
      res.error = word.last && (len_r != '0);
    end else begin
      cnt_nxt   = cnt_inc;
      pos_nxt   = mfd_pkg::POS_PAYLOAD;
      res.kind  = mfd_pkg::KIND_PAYLOAD;
      res.data  = word.data ^ key_byte;
      res.last  = word.last;
      res.error = word.last && (cnt_inc != {1'b0, len_r});
    end
    // drop all frame state at the end of a buffer
    if (word.last) begin
      pos_nxt = '0;
      opc_nxt = '0;
      len_nxt = '0;
      key_nxt = '0;
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      opc_r <= '0;
      len_r <= '0;
      key_r <= '0;
      cnt_r <= '0;
    end else if (take) begin
      pos_r <= pos_nxt;
      opc_r <= opc_nxt;
      len_r <= len_nxt;
      key_r <= key_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/core/mfd_out_stage.sv =====
// ---------------------------------------------------------------------------
// mfd_out_stage
// Result register: hold one result word until the sink takes it.
// ---------------------------------------------------------------------------
module mfd_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  mfd_pkg::result_t res,
  output logic             out_free,
  mfd_out_if.source        out_ch
);

  logic             valid_r;
  logic             valid_nxt;
  mfd_pkg::result_t res_r;

  assign out_free = !valid_r || out_ch.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_ch.valid     = valid_r;
  assign out_ch.out_kind  = res_r.kind;
  assign out_ch.out_byte  = res_r.data;
  assign out_ch.out_last  = res_r.last;
  assign out_ch.out_error = res_r.error;

endmodule

// ===== rtl/core/masked_frame_deframer_core.sv =====
// Input register, parse, result register: a result loads once the result register is free.
// Throughput: one word per cycle, sustained while the sink takes every result; set by the
//   combinational parse between the input register and the result register.
// Header words before the last key byte give no result unless flagged last; those that give
//   none never wait on the sink.
// Reset (rst_n low, synchronous) empties both registers and clears all frame state.
// ---------------------------------------------------------------------------
// masked_frame_deframer_core
// Unpacks a masked, length-prefixed frame: opcode, 4-byte length, 4-byte key,
// payload. Gives the unmasked opcode, each unmasked payload byte, and a size
// check or truncation report on the buffer's last word.
// ---------------------------------------------------------------------------
module masked_frame_deframer_core (
  input  logic      clk,
  input  logic      rst_n,
  mfd_in_if.sink    in_ch,
  mfd_out_if.source out_ch
);

  mfd_pkg::in_word_t word;
  logic              word_valid;
  logic              take;
  logic              res_load;
  logic              out_free;
  mfd_pkg::result_t  res;

  // Capture each incoming word; ready stays high while the parser keeps up.
  mfd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .take       (take),
    .word       (word),
    .word_valid (word_valid)
  );

  // Advance the header position, collect length and key, unmask the payload.
  // A word that yields a result waits only while the result register is full and not taken.
  mfd_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .word       (word),
    .word_valid (word_valid),
    .out_free   (out_free),
    .take       (take),
    .res_load   (res_load),
    .res        (res)
  );

  // Hold the result word for the sink; refill in the cycle it is taken.
  mfd_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (res_load),
    .res      (res),
    .out_free (out_free),
    .out_ch   (out_ch)
  );

endmodule

// ===== rtl/core/mfd_checker.sv =====
// ---------------------------------------------------------------------------
// mfd_checker
// Port-level checks of the deframer result channel.
// ---------------------------------------------------------------------------
module mfd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [7:0] out_byte,
  input logic       out_last,
  input logic       out_error
);

  // a truncated header is always the final, failed word of its buffer
  a_trunc_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == mfd_pkg::KIND_TRUNC)
      |-> out_last && out_error && (out_byte == 8'd0))
    else $error("truncation word malformed");

  // errors are only reported on the last word of a buffer
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_last)
    else $error("error flag on a non-last word");

  // nothing is shown in the cycle after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind)
      && $stable(out_byte) && $stable(out_last) && $stable(out_error))
    else $error("stalled result changed");

endmodule

bind masked_frame_deframer_core mfd_checker u_mfd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_kind  (out_ch.out_kind),
  .out_byte  (out_ch.out_byte),
  .out_last  (out_ch.out_last),
  .out_error (out_ch.out_error)
);

// ===== tb/tb_masked_frame_deframer_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_masked_frame_deframer_core
// Streams framed buffers (masked opcode, big-endian length, key, payload)
// through the deframer with bursty input and a stalling sink, predicts every
// unmasked word and end-of-buffer status in a scoreboard, and checks each
// result word in order.
// ---------------------------------------------------------------------------
module tb_masked_frame_deframer_core;

  // Predicts the deframer's result words and matches them as they arrive.
  class frame_unmask_scoreboard;
    logic [mfd_pkg::POS_W-1:0]   hdr_pos;
    logic [7:0]                  opcode_raw;
    logic [mfd_pkg::LEN_W-1:0]   frame_len;
    logic [mfd_pkg::KEY_W-1:0]   mask_key;
    logic [mfd_pkg::COUNT_W-1:0] pay_count;
    mfd_pkg::result_t            expected_words[$];
    int unsigned                 mismatches;

    function new();
      mismatches = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      hdr_pos    = mfd_pkg::POS_OPCODE;
      opcode_raw = '0;
      frame_len  = '0;
      mask_key   = '0;
      pay_count  = '0;
    endfunction

    // key lane 0 is the first key byte received, held in the top bits
    function logic [7:0] key_lane(logic [1:0] lane);
      return mask_key[8*(3-lane) +: 8];
    endfunction

    function void note_word(logic [7:0] data, logic last);
      mfd_pkg::result_t            r;
      logic [mfd_pkg::COUNT_W-1:0] idx;
      logic                        gives;
      gives = 1'b0;
      r = '0;
      if (hdr_pos < mfd_pkg::POS_KEY_END) begin
        if (hdr_pos == mfd_pkg::POS_OPCODE)
          opcode_raw = data;
        else if (hdr_pos <= mfd_pkg::POS_LEN_END)
          frame_len = {frame_len[mfd_pkg::LEN_W-9:0], data};
        else
          mask_key = {mask_key[mfd_pkg::KEY_W-9:0], data};
        hdr_pos = hdr_pos + 1'b1;
        if (last) begin
          r.kind  = mfd_pkg::KIND_TRUNC;
          r.data  = 8'h00;
          r.last  = 1'b1;
          r.error = 1'b1;
          gives   = 1'b1;
        end
      end else if (hdr_pos == mfd_pkg::POS_KEY_END) begin
        mask_key = {mask_key[mfd_pkg::KEY_W-9:0], data};
        hdr_pos  = mfd_pkg::POS_PAYLOAD;
        r.kind   = mfd_pkg::KIND_OPCODE;
        r.data   = opcode_raw ^ key_lane(2'd0);
        r.last   = last;
        r.error  = last && (frame_len != '0);
        gives    = 1'b1;
      end else begin
        idx = pay_count;
        if (pay_count != '1)
          pay_count = pay_count + 1'b1;
        r.kind  = mfd_pkg::KIND_PAYLOAD;
        r.data  = data ^ key_lane(idx[1:0] + 2'd1);
        r.last  = last;
        r.error = last && (pay_count != {1'b0, frame_len});
        gives   = 1'b1;
      end
      if (gives)
        expected_words.insert(expected_words.size(), r);
      if (last)
        clear_frame();
    endfunction

    function void check_result(logic [1:0] kind, logic [7:0] data, logic last, logic error);
      mfd_pkg::result_t exp_w;
      if (expected_words.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word, expected none, actual kind=%0d byte=%02h last=%0b error=%0b",
                 $time, kind, data, last, error);
        return;
      end
      exp_w = expected_words.pop_front();
      if (exp_w.kind !== kind || exp_w.data !== data ||
          exp_w.last !== last || exp_w.error !== error) begin
        mismatches++;
        $display("%0t: word mismatch expected kind=%0d byte=%02h last=%0b error=%0b",
                 $time, exp_w.kind, exp_w.data, exp_w.last, exp_w.error);
        $display("%0t:                 actual kind=%0d byte=%02h last=%0b error=%0b",
                 $time, kind, data, last, error);
      end
    endfunction
  endclass

  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned TARGET_WORDS = 550;

  logic clk;
  logic rst_n;

  mfd_in_if  in_ch();
  mfd_out_if out_ch();

  masked_frame_deframer_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  frame_unmask_scoreboard sb;
  int unsigned words_sent;
  int unsigned burst_left;
  int unsigned idle_cycles = 0;
  int unsigned sink_cycle  = 0;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Note accepted input first, then check the result word of the same edge;
  // the result path is registered, so an edge never pairs a word with its own result.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_word(in_ch.in_byte, in_ch.in_last);
      if (out_ch.valid && out_ch.ready)
        sb.check_result(out_ch.out_kind, out_ch.out_byte, out_ch.out_last, out_ch.out_error);
    end
  end

  // Sink stall pattern: rotate through always-ready, light random stalls,
  // a fixed periodic stall and heavy random stalls.
  always @(posedge clk) begin
    sink_cycle <= sink_cycle + 1;
    case ((sink_cycle / 150) % 4)
      0: begin
        out_ch.ready <= 1'b1;
      end
      1: begin
        out_ch.ready <= ($urandom_range(0, 3) != 0);
      end
      2: begin
        out_ch.ready <= ((sink_cycle % 5) != 0);
      end
      default: begin
        out_ch.ready <= ($urandom_range(0, 1) == 1);
      end
    endcase
  end

  // Watchdog: end the run once nothing has moved for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: watchdog expired, no word moved in %0d cycles", $time, STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Drive one word and hold it until accepted. Between bursts, drop valid
  // for a random gap; a zero gap keeps valid high across the burst boundary.
  task automatic send_word(input logic [7:0] data, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= data;
    in_ch.in_last <= last;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
  endtask

  // Send one buffer. A cut of 0..8 ends the buffer on that header byte;
  // a negative cut sends the whole header and n_pay payload bytes.
  task automatic send_frame(input logic [7:0] opcode, input logic [31:0] len,
                            input logic [31:0] key, input int n_pay, input int cut);
    logic [7:0] hdr [9];
    int         total;
    int         i;
    hdr = '{opcode, len[31:24], len[23:16], len[15:8], len[7:0],
            key[31:24], key[23:16], key[15:8], key[7:0]};
    total = (cut >= 0) ? cut + 1 : int'(mfd_pkg::HDR_BYTES) + n_pay;
    for (i = 0; i < total; i++)
      send_word((i < int'(mfd_pkg::HDR_BYTES)) ? hdr[i] : 8'($urandom), i == total - 1);
  endtask

  initial begin
    int unsigned pick;
    int          n_pay;
    logic [31:0] len;

    sb            = new();
    words_sent    = 0;
    burst_left    = 0;
    rst_n         = 1'b0;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = 8'h00;
    in_ch.in_last = 1'b0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: truncation on the opcode byte, empty payload with zero
    // length, and an all-ones length with a short payload over every key lane.
    send_frame(8'hFF, 32'h0000_0000, 32'h0000_0000, 0, 0);
    send_frame(8'h00, 32'h0000_0000, 32'hFFFF_FFFF, 0, -1);
    send_frame(8'h5A, 32'hFFFF_FFFF, 32'hA5C3_0F81, 4, -1);

    // Random: mostly well-formed frames, plus size mismatches, truncated
    // headers and huge declared lengths.
    while (words_sent < TARGET_WORDS) begin
      pick  = $urandom_range(0, 99);
      n_pay = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 12);
      if (pick < 65) begin
        send_frame(8'($urandom), 32'(n_pay), $urandom, n_pay, -1);
      end else if (pick < 80) begin
        if (n_pay > 0 && $urandom_range(0, 1) == 1)
          len = 32'(n_pay - $urandom_range(1, n_pay));
        else
          len = 32'(n_pay + $urandom_range(1, 3));
        send_frame(8'($urandom), len, $urandom, n_pay, -1);
      end else if (pick < 92) begin
        send_frame(8'($urandom), $urandom, $urandom, 0, $urandom_range(0, 7));
      end else begin
        send_frame(8'($urandom), $urandom | 32'h8000_0000, $urandom,
                   $urandom_range(0, 4), -1);
      end
    end
    in_ch.valid <= 1'b0;

    // Drain outstanding results, then idle with the input quiet to catch strays.
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (sb.mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/mfd_pkg.sv
rtl/core/mfd_in_if.sv
rtl/core/mfd_out_if.sv
rtl/core/mfd_in_stage.sv
rtl/core/mfd_parse.sv
rtl/core/mfd_out_stage.sv
rtl/core/masked_frame_deframer_core.sv
rtl/core/mfd_checker.sv
tb/tb_masked_frame_deframer_core.sv
